>>> design/rrbc_pkg.sv
// Shared types, codes and constants of the biquad cascade resampler.
package rrbc_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int DEF_MAX_SECTIONS = 8;
    localparam int DEF_MAX_FACTOR   = 16;
    localparam int STATE_BITS       = 48;
    localparam int COEF_BITS        = 32;
    localparam int CFG_INDEX_BITS   = 2;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_COEF   = 2'd1;
    localparam logic [1:0] KIND_STATE  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UPSAMPLE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DOWNSAMPLE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN       = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SECTIONS   = 2'd3;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [5:0]                    entry_index;
        logic signed [STATE_BITS-1:0]  entry_value;
    } s_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] filtered_sample;
        logic                          last_of_run;
    } m_item_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_LO   = 2'd1,
        MUL_HI   = 2'd2,
        MUL_FIN  = 2'd3
    } mul_op_t;

    typedef enum logic [2:0] {
        ACC_NONE = 3'd0,
        ACC_LOAD = 3'd1,
        ACC_SUB  = 3'd2,
        ACC_ADDS = 3'd3
    } acc_op_t;

    // Address fields are sized for the largest supported section count.
    typedef struct packed {
        logic       item_load;
        logic       coef_wr;
        logic       state_wr_item;
        logic       state_clear;
        logic [7:0] coef_addr;
        logic [5:0] state_addr;
        mul_op_t    mul_op;
        logic       use_gain;
        logic       src_y;
        acc_op_t    acc_op;
        logic       y_load;
        logic       state_wr_acc;
        logic       v_load_sample;
        logic       v_from_y;
        logic       out_load;
        logic       out_last;
    } rrbc_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_free;
    } rrbc_status_t;

endpackage

>>> design/rrbc_ctrl.sv
// Sequencer that steps items, passes, sections and products through the datapath.
module rrbc_ctrl #(
    parameter int MAX_SECTIONS = rrbc_pkg::DEF_MAX_SECTIONS,
    parameter int MAX_FACTOR   = rrbc_pkg::DEF_MAX_FACTOR
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [4:0]           up_raw,
    input  logic [4:0]           down_raw,
    input  logic [3:0]           sec_raw,
    input  rrbc_pkg::rrbc_status_t status,
    output rrbc_pkg::rrbc_cmd_t  cmd
);
    import rrbc_pkg::*;

    localparam int PL_W  = $clog2(MAX_FACTOR + 1);
    localparam int NS_W  = $clog2(MAX_SECTIONS + 1);
    localparam int CF_AW = $clog2(5 * MAX_SECTIONS);
    localparam int ST_AW = $clog2(2 * MAX_SECTIONS);

    localparam logic [2:0] T_B0 = 3'd0;
    localparam logic [2:0] T_B1 = 3'd1;
    localparam logic [2:0] T_A1 = 3'd2;
    localparam logic [2:0] T_B2 = 3'd3;
    localparam logic [2:0] T_A2 = 3'd4;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_EXEC  = 13'b0000000000010,
        ST_START = 13'b0000000000100,
        ST_RD    = 13'b0000000001000,
        ST_MLO   = 13'b0000000010000,
        ST_MHI   = 13'b0000000100000,
        ST_MFIN  = 13'b0000001000000,
        ST_ACC   = 13'b0000010000000,
        ST_ADDS  = 13'b0000100000000,
        ST_YLD   = 13'b0001000000000,
        ST_WRS   = 13'b0010000000000,
        ST_PEND  = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PL_W-1:0]   phase_reg, phase_next;
    logic [PL_W-1:0]   pass_left_reg, pass_left_next;
    logic [NS_W-1:0]   sec_reg, sec_next;
    logic [CF_AW-1:0]  base_reg, base_next;
    logic [2:0]        t_reg, t_next;
    logic              gain_reg, gain_next;

    logic [PL_W-1:0]   p_val, q_val, ph1;
    logic [NS_W-1:0]   nsec_val;
    logic [2:0]        coef_off;
    logic              st_lsb;
    logic [CF_AW-1:0]  coef_addr;
    logic [ST_AW-1:0]  state_addr;

    always_comb begin
        if (up_raw == 5'd0) begin
            p_val = PL_W'(1);
        end else if (int'(up_raw) > MAX_FACTOR) begin
            p_val = PL_W'(MAX_FACTOR);
        end else begin
            p_val = PL_W'(up_raw);
        end
        if (down_raw == 5'd0) begin
            q_val = PL_W'(1);
        end else if (int'(down_raw) > MAX_FACTOR) begin
            q_val = PL_W'(MAX_FACTOR);
        end else begin
            q_val = PL_W'(down_raw);
        end
        if (sec_raw == 4'd0) begin
            nsec_val = NS_W'(1);
        end else if (int'(sec_raw) > MAX_SECTIONS) begin
            nsec_val = NS_W'(MAX_SECTIONS);
        end else begin
            nsec_val = NS_W'(sec_raw);
        end
    end

    // Products run in the order b0, b1, a1, b2, a2; the table holds b0 b1 b2 a1 a2.
    always_comb begin
        case (t_reg)
            T_B0:    coef_off = 3'd0;
            T_B1:    coef_off = 3'd1;
            T_A1:    coef_off = 3'd3;
            T_B2:    coef_off = 3'd2;
            default: coef_off = 3'd4;
        endcase
        if (state_reg == ST_WRS) begin
            st_lsb = (t_reg == T_A2);
        end else begin
            st_lsb = (t_reg != T_B0);
        end
        coef_addr  = base_reg + CF_AW'(coef_off);
        state_addr = ST_AW'({sec_reg, st_lsb});
    end

    assign ph1     = phase_reg + PL_W'(1);
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pass_left_next = pass_left_reg;
        sec_next       = sec_reg;
        base_next      = base_reg;
        t_next         = t_reg;
        gain_next      = gain_reg;
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        cmd.acc_op     = ACC_NONE;
        cmd.coef_addr  = 8'(coef_addr);
        cmd.state_addr = 6'(state_addr);
        cmd.use_gain   = gain_reg;
        cmd.src_y      = !gain_reg && (t_reg == T_A1 || t_reg == T_A2);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                unique case (status.kind)
                    KIND_SAMPLE: begin
                        pass_left_next = p_val;
                        state_next     = ST_START;
                    end
                    KIND_COEF:  cmd.coef_wr = 1'b1;
                    KIND_STATE: cmd.state_wr_item = 1'b1;
                    KIND_CLEAR: begin
                        cmd.state_clear = 1'b1;
                        phase_next      = '0;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_START: begin
                cmd.v_load_sample = 1'b1;
                sec_next          = '0;
                base_next         = '0;
                t_next            = T_B0;
                gain_next         = 1'b0;
                state_next        = ST_RD;
            end
            ST_RD:  state_next = ST_MLO;
            ST_MLO: begin
                cmd.mul_op = MUL_LO;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.mul_op = MUL_HI;
                state_next = ST_MFIN;
            end
            ST_MFIN: begin
                cmd.mul_op = MUL_FIN;
                state_next = gain_reg ? ST_PEND : ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_op = (t_reg == T_A1 || t_reg == T_A2) ? ACC_SUB : ACC_LOAD;
                if (t_reg == T_B0 || t_reg == T_A1) begin
                    state_next = ST_ADDS;
                end else if (t_reg == T_A2) begin
                    state_next = ST_WRS;
                end else begin
                    t_next     = t_reg + 3'd1;
                    state_next = ST_RD;
                end
            end
            ST_ADDS: begin
                cmd.acc_op = ACC_ADDS;
                state_next = (t_reg == T_B0) ? ST_YLD : ST_WRS;
            end
            ST_YLD: begin
                cmd.y_load = 1'b1;
                t_next     = T_B1;
                state_next = ST_RD;
            end
            ST_WRS: begin
                cmd.state_wr_acc = 1'b1;
                if (t_reg == T_A2) begin
                    cmd.v_from_y = 1'b1;
                    if (sec_reg + NS_W'(1) == nsec_val) begin
                        gain_next  = 1'b1;
                        state_next = ST_MLO;
                    end else begin
                        sec_next   = sec_reg + NS_W'(1);
                        base_next  = base_reg + CF_AW'(5);
                        t_next     = T_B0;
                        state_next = ST_RD;
                    end
                end else begin
                    t_next     = T_B2;
                    state_next = ST_RD;
                end
            end
            ST_PEND: begin
                pass_left_next = pass_left_reg - PL_W'(1);
                if (ph1 >= q_val) begin
                    phase_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    phase_next = ph1;
                    state_next = (pass_left_reg == PL_W'(1)) ? ST_IDLE : ST_START;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    // A further result needs a full downsample period of passes.
                    cmd.out_last = (pass_left_reg < q_val);
                    state_next   = (pass_left_reg == '0) ? ST_IDLE : ST_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            pass_left_reg <= '0;
            sec_reg       <= '0;
            base_reg      <= '0;
            t_reg         <= T_B0;
            gain_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pass_left_reg <= pass_left_next;
            sec_reg       <= sec_next;
            base_reg      <= base_next;
            t_reg         <= t_next;
            gain_reg      <= gain_next;
        end
    end

endmodule

>>> design/rrbc_dp.sv
// Datapath: coefficient and state memories, shared multiplier, accumulator, output register.
module rrbc_dp #(
    parameter int MAX_SECTIONS = rrbc_pkg::DEF_MAX_SECTIONS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrbc_pkg::s_item_t     s_data,
    input  logic signed [31:0]    gain,
    input  rrbc_pkg::rrbc_cmd_t   cmd,
    output rrbc_pkg::rrbc_status_t status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rrbc_pkg::m_item_t     m_data
);
    import rrbc_pkg::*;

    localparam int COEF_DEPTH  = 5 * MAX_SECTIONS;
    localparam int STATE_DEPTH = 2 * MAX_SECTIONS;
    localparam int CF_AW       = $clog2(COEF_DEPTH);
    localparam int ST_AW       = $clog2(STATE_DEPTH);

    logic signed [COEF_BITS-1:0]  coef_mem [COEF_DEPTH];
    logic signed [STATE_BITS-1:0] st_mem   [STATE_DEPTH];
    logic [STATE_DEPTH-1:0]       st_vld_reg;

    s_item_t                      item_reg;
    logic signed [COEF_BITS-1:0]  coef_q_reg;
    logic signed [STATE_BITS-1:0] st_q_reg;
    logic signed [STATE_BITS-1:0] v_reg, y_reg, x_reg, prod_reg;
    logic signed [COEF_BITS-1:0]  c_reg;
    logic signed [56:0]           p_lo_reg;
    logic signed [55:0]           p_hi_reg;
    logic signed [49:0]           acc_reg;
    logic                         m_valid_reg;
    m_item_t                      m_data_reg;

    logic [CF_AW-1:0]             coef_raddr, coef_waddr;
    logic [ST_AW-1:0]             st_addr, st_waddr;
    logic                         coef_idx_ok, st_idx_ok;
    logic signed [COEF_BITS-1:0]  coef_wval, c_sel;
    logic signed [STATE_BITS-1:0] x_sel, acc_sat, prod_sat;
    logic signed [80:0]           full_prod;
    logic signed [52:0]           shifted;
    logic signed [SAMPLE_BITS-1:0] out_sat;
    logic signed [STATE_BITS-1:0] st_wval;
    logic                         st_we;

    assign coef_raddr  = CF_AW'(cmd.coef_addr);
    assign st_addr     = ST_AW'(cmd.state_addr);
    assign coef_waddr  = CF_AW'(item_reg.entry_index);
    assign st_waddr    = ST_AW'(item_reg.entry_index);
    assign coef_idx_ok = int'(item_reg.entry_index) < COEF_DEPTH;
    assign st_idx_ok   = int'(item_reg.entry_index) < STATE_DEPTH;

    always_comb begin
        if (item_reg.entry_value[47:31] == '0 || item_reg.entry_value[47:31] == '1) begin
            coef_wval = item_reg.entry_value[31:0];
        end else if (item_reg.entry_value[47]) begin
            coef_wval = {1'b1, 31'b0};
        end else begin
            coef_wval = {1'b0, {31{1'b1}}};
        end

        if (acc_reg[49:47] == 3'b000 || acc_reg[49:47] == 3'b111) begin
            acc_sat = acc_reg[47:0];
        end else if (acc_reg[49]) begin
            acc_sat = {1'b1, 47'b0};
        end else begin
            acc_sat = {1'b0, {47{1'b1}}};
        end

        // Full 80-bit product from two 24-bit halves of the operand, then floor by 2^28.
        full_prod = {p_hi_reg[55], p_hi_reg, 24'b0} + {{24{p_lo_reg[56]}}, p_lo_reg};
        shifted   = full_prod[80:28];
        if (shifted[52:47] == '0 || shifted[52:47] == '1) begin
            prod_sat = shifted[47:0];
        end else if (shifted[52]) begin
            prod_sat = {1'b1, 47'b0};
        end else begin
            prod_sat = {1'b0, {47{1'b1}}};
        end

        if (prod_reg[STATE_BITS-1:SAMPLE_BITS-1] == '0 ||
            prod_reg[STATE_BITS-1:SAMPLE_BITS-1] == '1) begin
            out_sat = prod_reg[SAMPLE_BITS-1:0];
        end else if (prod_reg[STATE_BITS-1]) begin
            out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end

        c_sel = cmd.use_gain ? gain : coef_q_reg;
        x_sel = cmd.src_y ? y_reg : v_reg;

        st_we   = cmd.state_wr_acc || (cmd.state_wr_item && st_idx_ok);
        st_wval = cmd.state_wr_acc ? acc_sat : item_reg.entry_value;
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_wr && coef_idx_ok) begin
            coef_mem[coef_waddr] <= coef_wval;
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // Unwritten or cleared state words read as zero through the valid bits.
    always_ff @(posedge aclk) begin
        if (st_we) begin
            st_mem[cmd.state_wr_acc ? st_addr : st_waddr] <= st_wval;
        end
        st_q_reg <= st_vld_reg[st_addr] ? st_mem[st_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg <= '0;
        end else if (cmd.state_clear) begin
            st_vld_reg <= '0;
        end else if (st_we) begin
            st_vld_reg[cmd.state_wr_acc ? st_addr : st_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            item_reg <= s_data;
        end
        if (cmd.v_load_sample) begin
            v_reg <= STATE_BITS'(item_reg.sample);
        end else if (cmd.v_from_y) begin
            v_reg <= y_reg;
        end
        if (cmd.y_load) begin
            y_reg <= acc_sat;
        end
        case (cmd.mul_op)
            MUL_LO: begin
                c_reg    <= c_sel;
                x_reg    <= x_sel;
                p_lo_reg <= c_sel * $signed({1'b0, x_sel[23:0]});
            end
            MUL_HI:  p_hi_reg <= c_reg * $signed(x_reg[47:24]);
            MUL_FIN: prod_reg <= prod_sat;
            default: ;
        endcase
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= 50'(prod_reg);
            ACC_SUB:  acc_reg <= acc_reg - 50'(prod_reg);
            ACC_ADDS: acc_reg <= acc_reg + 50'(st_q_reg);
            default:  ;
        endcase
        if (cmd.out_load) begin
            m_data_reg.filtered_sample <= out_sat;
            m_data_reg.last_of_run     <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.kind     = item_reg.kind;
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

>>> design/rational_resampler_biquad_cascade.sv
// Top level of the rational resampler built on a biquad cascade.
//
// Input beats (s_valid/s_ready, s_data) carry one item each: a sample, a
// coefficient write, a state word write or a clear of state and phase.
// Result beats (m_valid/m_ready, m_data) carry one filtered sample each, with
// last_of_run set on the final result caused by an input sample.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it. One multiplier
// is shared; every product takes two multiply steps and a combine step, and the
// sequencer walks the five products of a section one after another.
// Reset clears all section state, the phase count and the registers to their
// defaults; coefficients hold whatever was written. A stalled receiver holds
// one result in the output register; the block keeps working until the next
// result is ready and then waits.
module rational_resampler_biquad_cascade #(
    parameter int MAX_SECTIONS = rrbc_pkg::DEF_MAX_SECTIONS,
    parameter int MAX_FACTOR   = rrbc_pkg::DEF_MAX_FACTOR
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rrbc_pkg::s_item_t                      s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rrbc_pkg::m_item_t                      m_data,
    input  logic                                   cfg_we,
    input  logic [rrbc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [31:0]                            cfg_wdata
);
    import rrbc_pkg::*;

    logic [4:0]         up_reg, down_reg;
    logic [3:0]         sec_reg;
    logic signed [31:0] gain_reg;
    rrbc_cmd_t          cmd;
    rrbc_status_t       status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= 5'd1;
            down_reg <= 5'd1;
            gain_reg <= 32'sh1000_0000;
            sec_reg  <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_UPSAMPLE:   up_reg   <= cfg_wdata[4:0];
                REG_DOWNSAMPLE: down_reg <= cfg_wdata[4:0];
                REG_GAIN:       gain_reg <= cfg_wdata;
                REG_SECTIONS:   sec_reg  <= cfg_wdata[3:0];
                default:        ;
            endcase
        end
    end

    rrbc_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .MAX_FACTOR   (MAX_FACTOR)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .up_raw   (up_reg),
        .down_raw (down_reg),
        .sec_raw  (sec_reg),
        .status   (status),
        .cmd      (cmd)
    );

    rrbc_dp #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .gain    (gain_reg),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> tb/sv/rational_resampler_biquad_cascade_tb.sv
// Self-checking testbench for the biquad cascade rational resampler.
`timescale 1ns / 100ps

module rational_resampler_biquad_cascade_tb;
    import rrbc_pkg::*;

    localparam int COEF_WORDS  = 5 * DEF_MAX_SECTIONS;
    localparam int STATE_WORDS = 2 * DEF_MAX_SECTIONS;
    localparam int SETTLE      = 4200;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    s_item_t s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    m_item_t m_data;
    logic    cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_UPSAMPLE;
    logic [31:0] cfg_wdata = '0;

    // Predicted block state and registers.
    logic signed [31:0] coef_mem [COEF_WORDS];
    logic signed [47:0] sec_mem [STATE_WORDS];
    int unsigned        pass_count;
    logic [4:0]         up_reg;
    logic [4:0]         down_reg;
    logic signed [31:0] gain_reg;
    logic [3:0]         sec_reg;

    s_item_t pending_items [$];
    m_item_t expected_samples [$];
    int      err_count = 0;
    bit      quiet = 1'b0;
    int      send_gap = 0;
    int      recv_gap = 0;

    rational_resampler_biquad_cascade uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic signed [47:0] sat48(input logic signed [95:0] x);
        if (x > 96'sd140737488355327) return 48'sh7fffffffffff;
        if (x < -96'sd140737488355328) return 48'sh800000000000;
        return x[47:0];
    endfunction

    // Fixed-point product: floor(c * v / 2^28), saturated to 48 bits.
    function automatic logic signed [47:0] fx_mul(input logic signed [31:0] c,
                                                  input logic signed [47:0] v);
        logic signed [95:0] p;
        p = c * v;
        return sat48(p >>> 28);
    endfunction

    function automatic int clamp_range(input int v, input int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic s_item_t mk_item(input logic [1:0] k, input logic [23:0] x,
                                        input logic [5:0] idx, input logic [47:0] val);
        s_item_t it;
        it.kind        = k;
        it.sample      = x;
        it.entry_index = idx;
        it.entry_value = val;
        return it;
    endfunction

    function automatic s_item_t mk_sample(input logic [23:0] x);
        return mk_item(KIND_SAMPLE, x, 6'($urandom()), rand48());
    endfunction

    function automatic s_item_t mk_coef(input int idx, input logic [47:0] val);
        return mk_item(KIND_COEF, 24'($urandom()), 6'(idx), val);
    endfunction

    // Moderate coefficient: b terms up to about 0.5, a terms up to about 0.25.
    function automatic logic [47:0] mild_coef(input int idx);
        int span;
        span = (idx % 5 < 3) ? (1 << 27) : (1 << 26);
        return 48'(signed'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic predict_item(input s_item_t it);
        int p, q, ns, j, r;
        logic signed [47:0] v, y, s0n, s1n;
        logic signed [95:0] t;
        m_item_t res;
        m_item_t run [$];
        case (it.kind)
            KIND_COEF: begin
                if (it.entry_index < COEF_WORDS) begin
                    if (it.entry_value > 48'sd2147483647)
                        coef_mem[it.entry_index] = 32'sh7fffffff;
                    else if (it.entry_value < -48'sd2147483648)
                        coef_mem[it.entry_index] = 32'sh80000000;
                    else
                        coef_mem[it.entry_index] = it.entry_value[31:0];
                end
            end
            KIND_STATE: begin
                if (it.entry_index < STATE_WORDS) sec_mem[it.entry_index] = it.entry_value;
            end
            KIND_CLEAR: begin
                foreach (sec_mem[i]) sec_mem[i] = '0;
                pass_count = 0;
            end
            default: begin
                p  = clamp_range(int'(up_reg), DEF_MAX_FACTOR);
                q  = clamp_range(int'(down_reg), DEF_MAX_FACTOR);
                ns = clamp_range(int'(sec_reg), DEF_MAX_SECTIONS);
                for (j = 0; j < p; j++) begin
                    v = 48'(it.sample);
                    for (r = 0; r < ns; r++) begin
                        t = fx_mul(coef_mem[r*5], v);
                        y = sat48(t + sec_mem[r*2]);
                        t = fx_mul(coef_mem[r*5+1], v);
                        t = t - fx_mul(coef_mem[r*5+3], y) + sec_mem[r*2+1];
                        s0n = sat48(t);
                        t = fx_mul(coef_mem[r*5+2], v);
                        t = t - fx_mul(coef_mem[r*5+4], y);
                        s1n = sat48(t);
                        sec_mem[r*2]   = s0n;
                        sec_mem[r*2+1] = s1n;
                        v = y;
                    end
                    y = fx_mul(gain_reg, v);
                    pass_count++;
                    if (pass_count >= q) begin
                        pass_count = 0;
                        if (y > 48'sd8388607) y = 48'sd8388607;
                        else if (y < -48'sd8388608) y = -48'sd8388608;
                        res.filtered_sample = y[23:0];
                        res.last_of_run     = 1'b0;
                        run.push_back(res);
                    end
                end
                if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
                foreach (run[i]) expected_samples.push_back(run[i]);
            end
        endcase
    endtask

    // Input driver: one beat at a time from the pending queue, with random gaps.
    always @(posedge aclk) begin
        logic    nv;
        s_item_t nd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_item(s_data);
            if (!(s_valid && !s_ready)) begin
                nv = 1'b0;
                nd = s_data;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    nd = pending_items.pop_front();
                    nv = 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
                end
                s_valid <= nv;
                s_data  <= nd;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        m_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected result beat: actual sample %0d last %0b",
                             $time, m_data.filtered_sample, m_data.last_of_run);
                    err_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_data.filtered_sample !== want.filtered_sample) begin
                        $display("%0t: filtered_sample mismatch: expected %0d actual %0d",
                                 $time, want.filtered_sample, m_data.filtered_sample);
                        err_count++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $display("%0t: last_of_run mismatch: expected %0b actual %0b",
                                 $time, want.last_of_run, m_data.last_of_run);
                        err_count++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0) recv_gap = $urandom_range(1, 16);
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_UPSAMPLE:   up_reg   = val[4:0];
            REG_DOWNSAMPLE: down_reg = val[4:0];
            REG_GAIN:       gain_reg = val;
            default:        sec_reg  = val[3:0];
        endcase
    endtask

    task automatic configure(input logic [31:0] up, input logic [31:0] dn,
                             input logic [31:0] g, input logic [31:0] ns);
        write_reg(REG_UPSAMPLE, up);
        write_reg(REG_DOWNSAMPLE, dn);
        write_reg(REG_GAIN, g);
        write_reg(REG_SECTIONS, ns);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Let every queued beat go out, every result come back, and the block go idle.
    task automatic drain();
        wait (pending_items.size() == 0 && !s_valid);
        wait (expected_samples.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_items(input int count, input bit big);
        int sel;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 72) begin
                pending_items.push_back(mk_sample(24'($urandom())));
            end else if (sel < 84) begin
                sel = $urandom_range(0, 47);
                pending_items.push_back(mk_coef(sel, ($urandom_range(0, 7) == 0) ?
                                                rand48() : mild_coef(sel)));
            end else if (sel < 95) begin
                pending_items.push_back(mk_item(KIND_STATE, 24'($urandom()),
                    6'($urandom_range(0, big ? 63 : 20)),
                    ($urandom_range(0, 3) == 0) ? rand48() : 48'(signed'($urandom()) >>> 8)));
            end else begin
                pending_items.push_back(mk_item(KIND_CLEAR, 24'($urandom()),
                                                6'($urandom()), rand48()));
            end
        end
    endtask

    initial begin
        int up, dn, ns;
        logic [31:0] g;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        foreach (sec_mem[i]) sec_mem[i] = '0;
        pass_count = 0;
        up_reg   = 5'd1;
        down_reg = 5'd1;
        gain_reg = 32'sh10000000;
        sec_reg  = 4'd1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Load the whole coefficient table before any sample reads it.
        for (int i = 0; i < COEF_WORDS; i++) pending_items.push_back(mk_coef(i, mild_coef(i)));

        // Directed items under the reset settings.
        pending_items.push_back(mk_sample(24'h7fffff));
        pending_items.push_back(mk_sample(24'h800000));
        pending_items.push_back(mk_sample(24'h000000));
        pending_items.push_back(mk_sample(24'hffffff));
        pending_items.push_back(mk_coef(0, 48'h7fffffffffff));
        pending_items.push_back(mk_sample(24'h400000));
        pending_items.push_back(mk_coef(0, 48'h800000000000));
        pending_items.push_back(mk_sample(24'h123456));
        pending_items.push_back(mk_coef(1, 48'h000080000000));
        pending_items.push_back(mk_coef(3, 48'hffff7fffffff));
        pending_items.push_back(mk_coef(40, 48'h000010000000));
        pending_items.push_back(mk_coef(63, rand48()));
        pending_items.push_back(mk_item(KIND_STATE, 24'h0, 6'd0, 48'h7fffffffffff));
        pending_items.push_back(mk_item(KIND_STATE, 24'h0, 6'd1, 48'h800000000000));
        pending_items.push_back(mk_item(KIND_STATE, 24'h0, 6'd16, rand48()));
        pending_items.push_back(mk_item(KIND_STATE, 24'h0, 6'd63, rand48()));
        pending_items.push_back(mk_sample(24'h7fffff));
        pending_items.push_back(mk_item(KIND_CLEAR, 24'hffffff, 6'h3f, 48'hffffffffffff));
        pending_items.push_back(mk_sample(24'h800000));
        pending_items.push_back(mk_coef(0, mild_coef(0)));
        pending_items.push_back(mk_coef(1, mild_coef(1)));
        pending_items.push_back(mk_coef(3, mild_coef(3)));
        pending_items.push_back(mk_sample(24'h7fffff));
        drain();

        // Largest upsample factor and section count, and extreme gain.
        configure(16, 1, 32'h80000000, 8);
        repeat (3) pending_items.push_back(mk_sample(24'($urandom())));
        pending_items.push_back(mk_sample(24'h7fffff));
        drain();

        // Zero factors and sections act as one; largest positive gain.
        configure(0, 0, 32'h7fffffff, 0);
        random_items(8, 1'b1);
        drain();

        // Long decimation leaves the phase count high, then the factor drops.
        configure(3, 16, 32'h10000000, 2);
        repeat (4) pending_items.push_back(mk_sample(24'($urandom())));
        drain();
        configure(1, 4, 32'h20000000, 3);
        repeat (4) pending_items.push_back(mk_sample(24'($urandom())));
        drain();

        // Out-of-range register values are clamped.
        configure(31, 31, 32'hf0000000, 15);
        repeat (3) pending_items.push_back(mk_sample(24'($urandom())));
        drain();

        // Random settings, mostly small and quick.
        repeat (6) begin
            up = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            dn = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            ns = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
            g  = ($urandom_range(0, 2) == 0) ? $urandom() :
                 32'($urandom_range(32'h04000000, 32'h20000000));
            configure(up, dn, g, ns);
            random_items(12, 1'b1);
            drain();
        end

        // Final stretch without idling on either side.
        configure(2, 3, 32'h0c000000, 2);
        quiet = 1'b1;
        random_items(20, 1'b0);
        drain();

        if (err_count == 0) begin
            $display("rational_resampler_biquad_cascade regression: pass");
        end else begin
            $display("rational_resampler_biquad_cascade regression: fail");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("rational_resampler_biquad_cascade regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
design/rrbc_pkg.sv
design/rrbc_ctrl.sv
design/rrbc_dp.sv
design/rational_resampler_biquad_cascade.sv
tb/sv/rational_resampler_biquad_cascade_tb.sv
